>>> hdl/grid_local_peak_finder_unit_assert.svh
// Assertion macros used by the checker file of the peak finder.
`ifndef GRID_LOCAL_PEAK_FINDER_UNIT_ASSERT_SVH
`define GRID_LOCAL_PEAK_FINDER_UNIT_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define GLPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked check that also holds while reset is asserted.
`define GLPF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

>>> hdl/glpf_pkg.sv
`timescale 1ns / 1ps

package glpf_pkg;

  localparam int MAX_COLS_DEF    = 32;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int MAX_ROWS    = 1024;
  localparam int PEAK_ROW_W  = 10;
  localparam int PEAK_COL_W  = 5;
  localparam int ROW_CNT_W   = 11;
  localparam int COL_CNT_W   = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 2'd0,
    REG_COL_COUNT = 2'd1
  } cfg_reg_e;

endpackage

>>> hdl/glpf_ram.sv
`timescale 1ns / 1ps

module glpf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/grid_local_peak_finder_unit.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+----------------------------------
// input    | in        | in_valid_i / in_stall_o    | sample_i
// result   | out       | out_valid_o / out_stall_i  | peak_row_o, peak_col_o, is_last_o
// config   | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// With no stall on the result side, an item passes through accept, line store fetch,
// judge, and hand-off of the held result. The fetch serves the two line store read ports.
// The last item of a frame adds a tail pass: prime, then read and judge per column.
// Reset clears only control state; no clearing pass runs over the line stores.
// A stalled result side holds the block in its judge or hand-off step.

module grid_local_peak_finder_unit #(
  parameter int MAX_COLS    = glpf_pkg::MAX_COLS_DEF,
  parameter int SAMPLE_BITS = glpf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0]     sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [glpf_pkg::PEAK_ROW_W-1:0]   peak_row_o,
  output logic [glpf_pkg::PEAK_COL_W-1:0]   peak_col_o,
  output logic                              is_last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [glpf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [glpf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  import glpf_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int EW = (CW + 1 > COL_CNT_W) ? CW + 1 : COL_CNT_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_FETCH  = 7'b0000010,
    S_JUDGE  = 7'b0000100,
    S_FLUSH  = 7'b0001000,
    S_TPRIME = 7'b0010000,
    S_TREAD  = 7'b0100000,
    S_TJUDGE = 7'b1000000
  } state_e;

  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  state_e                 state_q, state_d;
  logic [PEAK_ROW_W-1:0]  row_q, row_d;
  logic [CW-1:0]          col_q, col_d;
  logic                   sel_q, sel_d;
  logic [ROW_CNT_W-1:0]   row_count_q, row_count_d;
  logic [COL_CNT_W-1:0]   col_count_q, col_count_d;
  logic                   pend_valid_q, pend_valid_d;
  logic [PEAK_ROW_W-1:0]  pend_row_q, pend_row_d;
  logic [PEAK_COL_W-1:0]  pend_col_q, pend_col_d;
  logic                   out_valid_q, out_valid_d;
  logic [PEAK_ROW_W-1:0]  out_row_q, out_row_d;
  logic [PEAK_COL_W-1:0]  out_col_q, out_col_d;
  logic                   out_last_q, out_last_d;
  smp_t                   sample_q, sample_d;
  smp_t                   older_q, older_d;
  smp_t                   mid_q, mid_d;
  smp_t                   left_q, left_d;
  smp_t                   tl_q, tl_d;
  smp_t                   tm_q, tm_d;
  logic [CW-1:0]          t_q, t_d;
  logic [PEAK_ROW_W-1:0]  tail_row_q, tail_row_d;
  logic                   tail_up_q, tail_up_d;

  logic [PEAK_ROW_W-1:0]  last_row;
  logic [CW-1:0]          last_col;
  logic [EW-1:0]          cc_ext;

  logic                   up_rd_en, cur_rd_en, cur_wr_en;
  logic [CW-1:0]          up_rd_addr, cur_rd_addr, cur_wr_addr;
  logic [SAMPLE_BITS-1:0] b0_rd, b1_rd;
  smp_t                   up_rd, cur_rd;

  smp_t                   j_left, j_right, j_up, t_right, t_up;
  logic                   peak_a, peak_b;
  logic                   out_free, can_push;
  logic                   push_en;
  logic [PEAK_ROW_W-1:0]  push_row;
  logic [PEAK_COL_W-1:0]  push_col;

  glpf_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_COLS)
  ) u_bank0 (
    .clk_i    (clk_i),
    .wr_en_i  (cur_wr_en && sel_q),
    .wr_addr_i(cur_wr_addr),
    .wr_data_i(sample_q),
    .rd_en_i  (sel_q ? cur_rd_en : up_rd_en),
    .rd_addr_i(sel_q ? cur_rd_addr : up_rd_addr),
    .rd_data_o(b0_rd)
  );

  glpf_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_COLS)
  ) u_bank1 (
    .clk_i    (clk_i),
    .wr_en_i  (cur_wr_en && !sel_q),
    .wr_addr_i(cur_wr_addr),
    .wr_data_i(sample_q),
    .rd_en_i  (sel_q ? up_rd_en : cur_rd_en),
    .rd_addr_i(sel_q ? up_rd_addr : cur_rd_addr),
    .rd_data_o(b1_rd)
  );

  assign up_rd  = sel_q ? b1_rd : b0_rd;
  assign cur_rd = sel_q ? b0_rd : b1_rd;

  always_comb begin
    if (row_count_q == '0) begin
      last_row = '0;
    end else if (row_count_q > ROW_CNT_W'(MAX_ROWS)) begin
      last_row = PEAK_ROW_W'(MAX_ROWS - 1);
    end else begin
      last_row = PEAK_ROW_W'(row_count_q - ROW_CNT_W'(1));
    end
  end

  assign cc_ext = EW'(col_count_q);

  always_comb begin
    if (cc_ext == '0) begin
      last_col = '0;
    end else if (cc_ext > EW'(MAX_COLS)) begin
      last_col = CW'(MAX_COLS - 1);
    end else begin
      last_col = CW'(cc_ext - EW'(1));
    end
  end

  assign j_left  = (col_q != '0) ? left_q : '0;
  assign j_right = (col_q != last_col) ? up_rd : '0;
  assign j_up    = (row_q >= PEAK_ROW_W'(2)) ? older_q : '0;
  assign peak_a  = (row_q != '0) && (mid_q >= j_left) && (mid_q >= j_right) &&
                   (mid_q >= j_up) && (mid_q >= sample_q);

  assign t_right = (t_q != last_col) ? up_rd : '0;
  assign t_up    = tail_up_q ? cur_rd : '0;
  assign peak_b  = (tm_q >= tl_q) && (tm_q >= t_right) && (tm_q >= t_up) &&
                   (tm_q >= smp_t'(0));

  assign out_free = !out_valid_q || !out_stall_i;
  assign can_push = !pend_valid_q || out_free;

  always_comb begin
    state_d      = state_q;
    row_d        = row_q;
    col_d        = col_q;
    sel_d        = sel_q;
    row_count_d  = row_count_q;
    col_count_d  = col_count_q;
    pend_valid_d = pend_valid_q;
    pend_row_d   = pend_row_q;
    pend_col_d   = pend_col_q;
    out_valid_d  = out_valid_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    out_last_d   = out_last_q;
    sample_d     = sample_q;
    older_d      = older_q;
    mid_d        = mid_q;
    left_d       = left_q;
    tl_d         = tl_q;
    tm_d         = tm_q;
    t_d          = t_q;
    tail_row_d   = tail_row_q;
    tail_up_d    = tail_up_q;
    up_rd_en     = 1'b0;
    up_rd_addr   = col_q;
    cur_rd_en    = 1'b0;
    cur_rd_addr  = col_q;
    cur_wr_en    = 1'b0;
    cur_wr_addr  = col_q;
    push_en      = 1'b0;
    push_row     = '0;
    push_col     = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (cfg_valid_i) begin
          case (cfg_index_i)
            REG_ROW_COUNT: begin
              row_count_d = cfg_data_i[ROW_CNT_W-1:0];
              row_d       = '0;
              col_d       = '0;
            end
            REG_COL_COUNT: begin
              col_count_d = cfg_data_i[COL_CNT_W-1:0];
              row_d       = '0;
              col_d       = '0;
            end
            default: begin
            end
          endcase
        end else if (in_valid_i) begin
          sample_d  = sample_i;
          up_rd_en  = 1'b1;
          cur_rd_en = 1'b1;
          state_d   = S_FETCH;
        end
      end
      S_FETCH: begin
        older_d    = cur_rd;
        mid_d      = up_rd;
        cur_wr_en  = 1'b1;
        up_rd_en   = 1'b1;
        up_rd_addr = col_q + CW'(1);
        state_d    = S_JUDGE;
      end
      S_JUDGE: begin
        if (!peak_a || can_push) begin
          push_en  = peak_a;
          push_row = row_q - PEAK_ROW_W'(1);
          push_col = PEAK_COL_W'(col_q);
          left_d   = mid_q;
          if (col_q == last_col) begin
            sel_d = !sel_q;
            col_d = '0;
            if (row_q == last_row) begin
              row_d      = '0;
              tail_row_d = row_q;
              tail_up_d  = (row_q != '0);
              t_d        = '0;
              tl_d       = '0;
              state_d    = S_TPRIME;
            end else begin
              row_d   = row_q + PEAK_ROW_W'(1);
              state_d = S_FLUSH;
            end
          end else begin
            col_d   = col_q + CW'(1);
            state_d = S_FLUSH;
          end
        end
      end
      S_TPRIME: begin
        up_rd_en   = 1'b1;
        up_rd_addr = '0;
        state_d    = S_TREAD;
      end
      S_TREAD: begin
        if (t_q == '0) begin
          tm_d = up_rd;
        end
        up_rd_en    = 1'b1;
        up_rd_addr  = t_q + CW'(1);
        cur_rd_en   = 1'b1;
        cur_rd_addr = t_q;
        state_d     = S_TJUDGE;
      end
      S_TJUDGE: begin
        if (!peak_b || can_push) begin
          push_en  = peak_b;
          push_row = tail_row_q;
          push_col = PEAK_COL_W'(t_q);
          tl_d     = tm_q;
          tm_d     = t_right;
          if (t_q == last_col) begin
            state_d = S_FLUSH;
          end else begin
            t_d     = t_q + CW'(1);
            state_d = S_TREAD;
          end
        end
      end
      S_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_row_d    = pend_row_q;
          out_col_d    = pend_col_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (push_en) begin
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        out_row_d   = pend_row_q;
        out_col_d   = pend_col_q;
        out_last_d  = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_row_d   = push_row;
      pend_col_d   = push_col;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      row_q        <= '0;
      col_q        <= '0;
      sel_q        <= 1'b0;
      row_count_q  <= ROW_CNT_W'(1);
      col_count_q  <= COL_CNT_W'(1);
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      t_q          <= '0;
      tail_up_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      row_q        <= row_d;
      col_q        <= col_d;
      sel_q        <= sel_d;
      row_count_q  <= row_count_d;
      col_count_q  <= col_count_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      t_q          <= t_d;
      tail_up_q    <= tail_up_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_row_q <= pend_row_d;
    pend_col_q <= pend_col_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    out_last_q <= out_last_d;
    sample_q   <= sample_d;
    older_q    <= older_d;
    mid_q      <= mid_d;
    left_q     <= left_d;
    tl_q       <= tl_d;
    tm_q       <= tm_d;
    tail_row_q <= tail_row_d;
  end

  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign peak_row_o  = out_row_q;
  assign peak_col_o  = out_col_q;
  assign is_last_o   = out_last_q;

endmodule

>>> hdl/glpf_checker.sv
`timescale 1ns / 1ps

`include "grid_local_peak_finder_unit_assert.svh"

module glpf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [glpf_pkg::PEAK_ROW_W-1:0]   peak_row_o,
  input logic [glpf_pkg::PEAK_COL_W-1:0]   peak_col_o,
  input logic                              is_last_o,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o
);

  import glpf_pkg::*;

  property p_out_hold;
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable({peak_row_o, peak_col_o, is_last_o});
  endproperty

  // A stalled result keeps its fields.
  `GLPF_ASSERT(a_out_hold, p_out_hold, "stalled result changed")

  // The block works on one item at a time.
  `GLPF_ASSERT(a_one_item, in_valid_i && !in_stall_o |=> in_stall_o, "item taken while busy")

  // A register write and an item are never taken together.
  `GLPF_ASSERT(a_cfg_excl, cfg_valid_i && cfg_ready_o |-> in_stall_o, "item taken with write")

  // No result is offered in the cycle after a reset cycle.
  `GLPF_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !out_valid_o, "result during reset")

endmodule

bind grid_local_peak_finder_unit glpf_checker u_glpf_checker (.*);
